[rtl/cbmp_pkg.sv]
// Shared types and constants for the cubic Bezier motion profile block.
// No dependencies.
package cbmp_pkg;

   localparam int unsigned CoordBits = 32;
   localparam int unsigned FracBits  = 16;
   localparam int unsigned TBits     = 17;

   localparam logic [1:0] OP_EVAL  = 2'd0;
   localparam logic [1:0] OP_TABLE = 2'd1;
   localparam logic [1:0] OP_SOLVE = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOCONV  = 2'd1;
   localparam logic [1:0] ST_BADIDX  = 2'd2;

   localparam logic [2:0] REG_P0_X = 3'd0;

   typedef struct packed {
      logic [1:0]  op;
      logic [16:0] param;
      logic signed [31:0] target_x;
      logic [30:0] tolerance;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic [16:0] out_t;
      logic [1:0]  status;
      logic [4:0]  halvings;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_WT, S_WTWAIT, S_CX, S_CXWAIT, S_CHECK, S_CY, S_CYWAIT, S_DONE
   } state_type;

   // datapath commands from controller
   typedef struct packed {
      logic load;       // capture request, set up t
      logic wt_start;   // derive weights from t
      logic cmb_start;  // combine along one axis
      logic cmb_axis;   // 0 x, 1 y
      logic step;       // bisection move
      logic finish;     // load the output register
   } cmd_type;

   typedef struct packed {
      logic busy;       // multi-cycle unit still working
      logic table_mode; // weights come from table
      logic bad_index;
      logic within_tol;
      logic cap_reached;
   } sts_type;

endpackage

[rtl/cbmp_datapath.sv]
// Datapath: sequenced multipliers for the weights and for the coordinate sums.
// Depends on cbmp_pkg.
module cbmp_datapath #(
   parameter int unsigned TABLE_POINTS = 21,
   parameter int unsigned MAX_ITER     = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cbmp_pkg::req_type       req,
   input  logic [31:0]             cfg_regs [8],
   input  cbmp_pkg::cmd_type       cmd,
   output cbmp_pkg::sts_type       sts,
   output cbmp_pkg::rsp_type       rsp
);
   import cbmp_pkg::*;

   localparam int unsigned FRAC_BITS  = FracBits;
   localparam int unsigned COORD_BITS = CoordBits;
   localparam int unsigned N    = TABLE_POINTS - 1;
   localparam int unsigned IB   = $clog2(TABLE_POINTS);
   localparam int unsigned WB   = FRAC_BITS + 2;   // weight/t bits
   localparam int unsigned PB   = 2 * WB + 2;      // product bits
   localparam int unsigned AB   = 34 + WB + 2;     // accumulator bits
   localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

   // constant weight and t table at k/N
   logic [WB-1:0] tabw [TABLE_POINTS][4];
   logic [WB-1:0] tabt [TABLE_POINTS];
   logic [IB-1:0] tix;

   for (genvar k = 0; k < TABLE_POINTS; k++) begin : g_tab
      localparam longint unsigned KK = k;
      localparam longint unsigned A  = N - KK;
      localparam longint unsigned D  = longint'(N) * N * N;
      localparam logic [WB-1:0] W0 = WB'((A * A * A * ONE + D / 2) / D);
      localparam logic [WB-1:0] W1 = WB'((3 * KK * A * A * ONE + D / 2) / D);
      localparam logic [WB-1:0] W2 = WB'((3 * KK * KK * A * ONE + D / 2) / D);
      localparam logic [WB-1:0] W3 = WB'((KK * KK * KK * ONE + D / 2) / D);
      localparam logic [WB-1:0] TT = WB'((KK * ONE + N / 2) / N);
      assign tabw[k][0] = W0;
      assign tabw[k][1] = W1;
      assign tabw[k][2] = W2;
      assign tabw[k][3] = W3;
      assign tabt[k]    = TT;
   end

   assign tix = req.param[IB-1:0];

   // request and bisection state
   req_type          req_ff;
   logic [WB-1:0]    t_ff, t_in;
   logic [WB-1:0]    stp_ff;
   logic [5:0]       halv_ff;
   logic [WB-1:0]    w_ff [4];
   logic [WB-1:0]    u2_ff, t2_ff;
   logic signed [AB-1:0] acc_ff;
   logic signed [33:0]   x_ff, y_ff;
   logic [3:0]       seq_ff;      // micro-step counter
   logic             wt_busy_ff, cmb_busy_ff;
   logic             axis_ff;
   logic [PB-1:0]    prod;
   logic [WB-1:0]    ma, mb;
   logic             bad;
   logic [WB-1:0]    rnd_p;
   logic signed [AB-1:0] cterm;
   logic signed [33:0]   cres;
   logic signed [AB-1:0] racc, sat_hi, sat_lo;
   rsp_type          rsp_ff;

   assign bad = req_ff.op == OP_TABLE && req_ff.param > 17'(N);

   // one multiplier, operands picked by sequence step
   always_comb begin
      logic [WB-1:0] u;
      u = WB'(ONE) - t_ff;
      ma = '0;
      mb = '0;
      case (seq_ff)
         4'd0: begin ma = u;     mb = u;     end
         4'd1: begin ma = t_ff;  mb = t_ff;  end
         4'd2: begin ma = u2_ff; mb = u;     end
         4'd3: begin ma = t_ff;  mb = u2_ff; end
         4'd4: begin ma = t2_ff; mb = u;     end
         4'd5: begin ma = t2_ff; mb = t_ff;  end
         default: ;
      endcase
      prod  = PB'(ma) * PB'(mb);
      rnd_p = WB'((PB'(seq_ff == 4'd3 || seq_ff == 4'd4 ? prod * 3 : prod) + PB'(HALF))
                  >> FRAC_BITS);
   end

   always_comb begin
      logic signed [33:0] c;
      c = 34'(signed'(cfg_regs[{seq_ff[1:0], axis_ff}]));
      cterm = AB'(c) * signed'({1'b0, w_ff[seq_ff[1:0]]});
      racc  = (acc_ff + signed'(AB'(HALF))) >>> FRAC_BITS;
      sat_hi = AB'((64'd1 << (COORD_BITS - 1)) - 1);
      sat_lo = -sat_hi - AB'(1);
      if (racc > sat_hi)      cres = 34'(sat_hi);
      else if (racc < sat_lo) cres = 34'(sat_lo);
      else                    cres = 34'(racc);
   end

   always_comb begin
      t_in = t_ff;
      if (cmd.load) begin
         if (req.op == OP_EVAL)       t_in = req.param > 17'(ONE) ? WB'(ONE) : WB'(req.param);
         else if (req.op == OP_TABLE) t_in = req.param > 17'(N) ? '0 : tabt[tix];
         else                         t_in = WB'(HALF);
      end else if (cmd.step) begin
         t_in = (signed'(34'(signed'(req_ff.target_x))) < x_ff) ? t_ff - (stp_ff >> 1)
                                                               : t_ff + (stp_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      if (cmd.load) begin
         req_ff  <= req;
         stp_ff  <= WB'(HALF);
         halv_ff <= '0;
         if (req.op == OP_TABLE && req.param <= 17'(N)) begin
            for (int i = 0; i < 4; i++) w_ff[i] <= tabw[tix][i];
         end
      end
      if (cmd.step) begin
         stp_ff  <= stp_ff >> 1;
         halv_ff <= halv_ff + 6'd1;
      end
      if (reset) begin
         wt_busy_ff  <= 1'b0;
         cmb_busy_ff <= 1'b0;
         seq_ff      <= '0;
      end else if (cmd.wt_start) begin
         wt_busy_ff <= 1'b1;
         seq_ff     <= '0;
      end else if (cmd.cmb_start) begin
         cmb_busy_ff <= 1'b1;
         axis_ff     <= cmd.cmb_axis;
         acc_ff      <= '0;
         seq_ff      <= '0;
      end else if (wt_busy_ff) begin
         case (seq_ff)
            4'd0: u2_ff <= rnd_p;
            4'd1: t2_ff <= rnd_p;
            4'd2: w_ff[0] <= rnd_p;
            4'd3: w_ff[1] <= rnd_p;
            4'd4: w_ff[2] <= rnd_p;
            default: w_ff[3] <= rnd_p;
         endcase
         if (seq_ff == 4'd5) wt_busy_ff <= 1'b0;
         seq_ff <= seq_ff + 4'd1;
      end else if (cmb_busy_ff) begin
         if (seq_ff == 4'd4) begin
            cmb_busy_ff <= 1'b0;
            if (axis_ff) y_ff <= cres;
            else         x_ff <= cres;
         end else begin
            acc_ff <= acc_ff + cterm;
         end
         seq_ff <= seq_ff + 4'd1;
      end
   end

   always_comb begin
      logic signed [34:0] d;
      d = 35'(x_ff) - 35'(signed'(req_ff.target_x));
      if (d < 0) d = -d;
      sts.busy        = wt_busy_ff | cmb_busy_ff;
      sts.table_mode  = req_ff.op == OP_TABLE;
      sts.bad_index   = bad;
      sts.within_tol  = d <= 35'(req_ff.tolerance);
      sts.cap_reached = halv_ff >= 6'(MAX_ITER);
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.out_x    <= bad ? '0 : x_ff[31:0];
         rsp_ff.out_y    <= bad ? '0 : y_ff[31:0];
         rsp_ff.out_t    <= bad ? '0 : t_ff[16:0];
         rsp_ff.status   <= bad ? ST_BADIDX :
                            (req_ff.op == OP_SOLVE && !sts.within_tol) ? ST_NOCONV : ST_OK;
         rsp_ff.halvings <= halv_ff > 6'd31 ? 5'd31 : halv_ff[4:0];
      end
   end
   assign rsp = rsp_ff;
endmodule

[rtl/cbmp_control.sv]
// Controller state machine sequencing weight and combine passes.
// Depends on cbmp_pkg.
module cbmp_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output cbmp_pkg::cmd_type  cmd,
   input  cbmp_pkg::sts_type  sts
);
   import cbmp_pkg::*;

   state_type state_ff, state_in;
   logic      vld_ff, vld_in;
   logic      req_op_solve_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_op_solve_ff <= req_op == OP_SOLVE;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      vld_in    = vld_ff;
      if (rsp_ready) vld_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_op != OP_NONE) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: state_in = sts.bad_index ? S_DONE : (sts.table_mode ? S_CX : S_WT);
         S_WT: begin
            cmd.wt_start = 1'b1;
            state_in = S_WTWAIT;
         end
         S_WTWAIT: if (!sts.busy) state_in = S_CX;
         S_CX: begin
            cmd.cmb_start = 1'b1;
            state_in = S_CXWAIT;
         end
         S_CXWAIT: if (!sts.busy) state_in = S_CHECK;
         S_CHECK: begin
            if (!sts.table_mode && req_op_solve_ff && !sts.within_tol && !sts.cap_reached) begin
               cmd.step = 1'b1;
               state_in = S_WT;
            end else begin
               state_in = S_CY;
            end
         end
         S_CY: begin
            cmd.cmb_start = 1'b1;
            cmd.cmb_axis  = 1'b1;
            state_in = S_CYWAIT;
         end
         S_CYWAIT: if (!sts.busy) state_in = S_DONE;
         S_DONE: begin
            if (!vld_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               vld_in     = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = vld_ff;
endmodule

[rtl/cubic_bezier_motion_profile.sv]
// Top level of the cubic Bezier motion profile evaluator.
// Depends on cbmp_pkg, cbmp_control and cbmp_datapath.
//
// Evaluates a cubic Bezier curve whose four control points live in eight
// APB registers (p0_x at 0x00 to p3_y at 0x1C). Op 0 evaluates at t
// (Q1.16, saturated to 1.0), op 1 at table point k/(TABLE_POINTS-1), op 2
// bisects for t with |x(t)-target_x| <= tolerance. One item at a time on the
// sequenced multipliers: op 0 runs 6 weight multiplies, then 4+1 combine
// steps per axis, and the next transfer can be taken in the same cycle
// that its result becomes valid. Op 1 takes its weights from a constant
// table and skips the weight pass; an index out of range goes straight to
// the result. Op 2 repeats the weight pass and the x combine per bisection
// halving, up to MAX_ITER halvings. The result register lets the next
// transfer start while a finished result waits. Op 3 is accepted and
// dropped with no result.
module cubic_bezier_motion_profile #(
   parameter int unsigned TABLE_POINTS = 21,
   parameter int unsigned MAX_ITER     = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbmp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbmp_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import cbmp_pkg::*;

   logic [31:0] regs_ff [8];
   cmd_type     cmd;
   sts_type     sts;

   assign pready = 1'b1;
   // write at the access phase; byte addresses 4*i
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= '0;
      end else if (psel && penable && pwrite) begin
         regs_ff[paddr[4:2]] <= pwdata;
      end
   end
   assign prdata = regs_ff[paddr[4:2]];

   cbmp_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_op(req_data.op),
      .rsp_valid, .rsp_ready, .cmd, .sts
   );

   cbmp_datapath #(
      .TABLE_POINTS(TABLE_POINTS), .MAX_ITER(MAX_ITER)
   ) u_dp (
      .clock, .reset, .req(req_data), .cfg_regs(regs_ff), .cmd, .sts, .rsp(rsp_data)
   );
endmodule
